// ----- rtl/time_ordered_event_queue_defines.svh -----
// Assertion helpers used by the queue sequencer.
// Both expect signals named clk and rst in the module that uses them.
`ifndef TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/teq_pkg.sv -----
package teq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t OCC_FULL = cnt_t'(DEPTH);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NOMATCH = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] event_time;
    logic [7:0]  event_type;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [31:0] head_time;
    logic [7:0]  head_type;
    logic [4:0]  fill_count;
  } rsp_t;

  // One stored event.
  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  kind;
  } slot_t;

  // Write and read request to the slot store.
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    slot_t wdata;
    idx_t  raddr;
  } mem_req_t;

  // Outcome of the shared compare unit.
  typedef struct packed {
    logic earlier;
    logic match;
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_ISHIFT,
    ST_IPLACE,
    ST_RSHIFT,
    ST_HEAD,
    ST_FIN
  } state_t;

endpackage

// ----- rtl/time_ordered_event_queue.sv -----
// A full queue drops an insert without a scan. A finished result waits in the sequencer
// until the previous result has left the output register. The next request beat is taken
// once the sequencer is idle, even while the previous result still waits in that register.
// Reset: rst is synchronous and active high; it empties the queue and drops any result.
module time_ordered_event_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  teq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output teq_pkg::rsp_t rsp
);

  // The slot store has one write and one read port with registered read data. The
  // sequencer walks it one slot per cycle: a scan to find the position, then a shift
  // that opens or closes a gap, then a read of slot zero for the head.
  // Slot contents are not cleared, since only slots below the fill count are read.
  teq_pkg::mem_req_t mem;
  teq_pkg::slot_t    rdata;
  teq_pkg::rsp_t     res;
  logic              idle;
  logic              done;
  logic              start;
  logic              out_free;

  // A request beat is taken only when the sequencer has no work in flight.
  assign req_stall = !idle;
  assign start     = req_valid && !req_stall;

  // The output register may be refilled in the same cycle its beat leaves.
  assign out_free = !rsp_valid || !rsp_stall;

  teq_store u_store (
    .clk   (clk),
    .mem   (mem),
    .rdata (rdata)
  );

  teq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .rdata    (rdata),
    .out_free (out_free),
    .mem      (mem),
    .idle     (idle),
    .done     (done),
    .res      (res)
  );

  // Result register. It holds its beat steady while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= res;
    end
  end

endmodule

// ----- rtl/teq_store.sv -----
module teq_store (
  input  logic              clk,
  input  teq_pkg::mem_req_t mem,
  output teq_pkg::slot_t    rdata
);

  teq_pkg::slot_t slots [teq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (mem.we) begin
      slots[mem.waddr] <= mem.wdata;
    end
    rdata <= slots[mem.raddr];
  end

endmodule

// ----- rtl/teq_cmp.sv -----
module teq_cmp (
  input  logic [31:0]    new_stamp,
  input  logic [7:0]     new_kind,
  input  teq_pkg::slot_t slot,
  output teq_pkg::cmp_t  res
);

  logic [31:0] diff;

  // The new time is earlier when the wrapped difference is negative.
  assign diff        = new_stamp - slot.stamp;
  assign res.earlier = diff[31];
  assign res.match   = (new_kind == slot.kind);

endmodule

// ----- rtl/teq_seq.sv -----
`include "time_ordered_event_queue_defines.svh"

module teq_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  teq_pkg::req_t     req,
  input  teq_pkg::slot_t    rdata,
  input  logic              out_free,
  output teq_pkg::mem_req_t mem,
  output logic              idle,
  output logic              done,
  output teq_pkg::rsp_t     res
);

  teq_pkg::state_t state;
  teq_pkg::state_t state_next;
  teq_pkg::cnt_t   occ;
  teq_pkg::cnt_t   occ_next;
  teq_pkg::idx_t   rd_idx;
  teq_pkg::idx_t   rd_idx_next;
  teq_pkg::idx_t   pos;
  teq_pkg::idx_t   pos_next;
  logic [1:0]      status;
  logic [1:0]      status_next;
  teq_pkg::req_t   cur;
  teq_pkg::cmp_t   cmp;
  teq_pkg::idx_t   idx_inc;
  teq_pkg::idx_t   idx_dec;
  teq_pkg::idx_t   occ_last;
  logic            last;
  logic            is_insert;
  logic            hit;

  teq_cmp u_cmp (
    .new_stamp (cur.event_time),
    .new_kind  (cur.event_type),
    .slot      (rdata),
    .res       (cmp)
  );

  assign idx_inc   = rd_idx + teq_pkg::idx_t'(1);
  assign idx_dec   = rd_idx - teq_pkg::idx_t'(1);
  assign occ_last  = teq_pkg::idx_t'(occ - teq_pkg::cnt_t'(1));
  assign last      = (teq_pkg::cnt_t'(rd_idx) + teq_pkg::cnt_t'(1)) == occ;
  assign is_insert = (cur.req_type == teq_pkg::REQ_INSERT);
  assign hit       = is_insert ? cmp.earlier : cmp.match;
  assign idle      = (state == teq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= teq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_idx <= '0;
      pos    <= '0;
      status <= teq_pkg::STATUS_DONE;
    end else begin
      occ    <= occ_next;
      rd_idx <= rd_idx_next;
      pos    <= pos_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= req;
    end
  end

  always_comb begin
    state_next  = state;
    occ_next    = occ;
    rd_idx_next = rd_idx;
    pos_next    = pos;
    status_next = status;
    mem.we      = 1'b0;
    mem.waddr   = rd_idx;
    mem.wdata   = rdata;
    mem.raddr   = '0;
    done        = 1'b0;

    res.status     = status;
    res.head_valid = (occ != '0);
    res.head_time  = (occ != '0) ? rdata.stamp : 32'd0;
    res.head_type  = (occ != '0) ? rdata.kind : 8'd0;
    res.fill_count = 5'(occ);

    unique case (state)
      teq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = teq_pkg::ST_START;
        end
      end
      teq_pkg::ST_START: begin
        status_next = teq_pkg::STATUS_DONE;
        rd_idx_next = '0;
        if (is_insert) begin
          if (occ == teq_pkg::OCC_FULL) begin
            status_next = teq_pkg::STATUS_FULL;
            state_next  = teq_pkg::ST_HEAD;
          end else if (occ == '0) begin
            pos_next   = '0;
            state_next = teq_pkg::ST_IPLACE;
          end else begin
            state_next = teq_pkg::ST_SCAN;
          end
        end else begin
          if (occ == '0) begin
            status_next = teq_pkg::STATUS_NOMATCH;
            state_next  = teq_pkg::ST_HEAD;
          end else begin
            state_next = teq_pkg::ST_SCAN;
          end
        end
      end
      teq_pkg::ST_SCAN: begin
        if (hit) begin
          pos_next = rd_idx;
          if (is_insert) begin
            mem.raddr   = occ_last;
            rd_idx_next = occ_last;
            state_next  = teq_pkg::ST_ISHIFT;
          end else if (last) begin
            occ_next   = occ - teq_pkg::cnt_t'(1);
            state_next = teq_pkg::ST_HEAD;
          end else begin
            mem.raddr   = idx_inc;
            rd_idx_next = idx_inc;
            state_next  = teq_pkg::ST_RSHIFT;
          end
        end else if (last) begin
          if (is_insert) begin
            pos_next   = teq_pkg::idx_t'(occ);
            state_next = teq_pkg::ST_IPLACE;
          end else begin
            status_next = teq_pkg::STATUS_NOMATCH;
            state_next  = teq_pkg::ST_HEAD;
          end
        end else begin
          mem.raddr   = idx_inc;
          rd_idx_next = idx_inc;
        end
      end
      teq_pkg::ST_ISHIFT: begin
        mem.we    = 1'b1;
        mem.waddr = idx_inc;
        if (rd_idx == pos) begin
          state_next = teq_pkg::ST_IPLACE;
        end else begin
          mem.raddr   = idx_dec;
          rd_idx_next = idx_dec;
        end
      end
      teq_pkg::ST_IPLACE: begin
        mem.we     = 1'b1;
        mem.waddr  = pos;
        mem.wdata  = '{stamp: cur.event_time, kind: cur.event_type};
        occ_next   = occ + teq_pkg::cnt_t'(1);
        state_next = teq_pkg::ST_HEAD;
      end
      teq_pkg::ST_RSHIFT: begin
        mem.we    = 1'b1;
        mem.waddr = idx_dec;
        if (last) begin
          occ_next   = occ - teq_pkg::cnt_t'(1);
          state_next = teq_pkg::ST_HEAD;
        end else begin
          mem.raddr   = idx_inc;
          rd_idx_next = idx_inc;
        end
      end
      teq_pkg::ST_HEAD: begin
        state_next = teq_pkg::ST_FIN;
      end
      teq_pkg::ST_FIN: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = teq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = teq_pkg::ST_IDLE;
      end
    endcase
  end

  `TEQ_ASSERT_SAME(a_occ_bound, 1'b1, occ <= teq_pkg::OCC_FULL, "occupancy above depth")
  `TEQ_ASSERT_SAME(a_wr_range, mem.we, teq_pkg::cnt_t'(mem.waddr) <= occ, "write past fill")
  `TEQ_ASSERT_NEXT(a_busy, start, state != teq_pkg::ST_IDLE, "accepted beat left idle")
  `TEQ_ASSERT_SAME(a_rshift_idx, state == teq_pkg::ST_RSHIFT, teq_pkg::cnt_t'(rd_idx) < occ,
                   "remove shift past fill")
  `TEQ_ASSERT_SAME(a_ishift_idx, state == teq_pkg::ST_ISHIFT, rd_idx >= pos,
                   "insert shift below position")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

// Testbench for the time-ordered event queue.
//
// Every request beat that the queue accepts is also applied to a shadow copy of the
// queue kept here. The shadow copy is a sorted array of (time, kind) pairs. The report
// that the shadow copy produces for the beat is pushed onto a list of owed reports.
// Each report beat that the queue hands back is compared, field by field, with the
// oldest owed report.
//
// The stimulus has two parts. A short directed table comes first. It covers the empty
// queue, the extremes of the time and type fields, the ordering of times half a wrap
// apart, equal times, a remove whose time field is junk, a remove that finds nothing,
// and an insert into a full queue. Then a long random part swings the fill level
// between empty and full, so that full drops and failed removes keep coming. Its times
// mostly sit close to a slowly advancing base that wraps through zero.
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BEATS = 375;

  // One row of the directed table. When has_want is set, want is the report typed in
  // by hand. Otherwise the shadow queue supplies the expected report.
  typedef struct packed {
    teq_pkg::req_t beat;
    logic          has_want;
    teq_pkg::rsp_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [25] = '{
    // Removing from an empty queue finds nothing and reports an empty head.
    '{'{teq_pkg::REQ_REMOVE, 32'h0000_0000, 8'h00}, 1'b1,
      '{teq_pkg::STATUS_NOMATCH, 1'b0, 32'h0, 8'h00, 5'd0}},
    '{'{teq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 8'hFF}, 1'b1,
      '{teq_pkg::STATUS_DONE, 1'b1, 32'hFFFF_FFFF, 8'hFF, 5'd1}},
    // Time zero is one tick after all ones, so it lands behind the head.
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0000, 8'h00}, 1'b1,
      '{teq_pkg::STATUS_DONE, 1'b1, 32'hFFFF_FFFF, 8'hFF, 5'd2}},
    // These two sit exactly half a wrap away from stored times.
    '{'{teq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 8'h01}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h8000_0000, 8'h02}, 1'b0, '0},
    // Two equal times must keep their arrival order.
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0064, 8'h10}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0064, 8'h11}, 1'b0, '0},
    // The time field of a remove is junk and must be ignored.
    '{'{teq_pkg::REQ_REMOVE, 32'hDEAD_BEEF, 8'h10}, 1'b0, '0},
    '{'{teq_pkg::REQ_REMOVE, 32'h0000_0000, 8'h55}, 1'b0, '0},
    '{'{teq_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 8'hFF}, 1'b0, '0},
    // Twelve inserts bring the queue from four events to full.
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0010, 8'h20}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h7FFF_FFF0, 8'h80}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'hFFFF_FF00, 8'h7F}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0064, 8'h21}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h5555_5555, 8'h22}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'hAAAA_AAAA, 8'h23}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0200, 8'h01}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'hFFFF_FFFE, 8'hFE}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0001, 8'h24}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h1234_5678, 8'h25}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h8000_0001, 8'h26}, 1'b0, '0},
    '{'{teq_pkg::REQ_INSERT, 32'h0000_0064, 8'h27}, 1'b0, '0},
    // The queue is full now, so this insert is dropped.
    '{'{teq_pkg::REQ_INSERT, 32'h1234_5678, 8'hAA}, 1'b0, '0},
    '{'{teq_pkg::REQ_REMOVE, 32'h0000_0000, 8'hAA}, 1'b0, '0},
    '{'{teq_pkg::REQ_REMOVE, 32'h0000_0000, 8'h02}, 1'b0, '0}
  };

  logic          clk;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  teq_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  teq_pkg::rsp_t rsp;

  // Shadow copy of the queue, earliest event in entry 0.
  logic [31:0] shadow_time [teq_pkg::DEPTH];
  logic [7:0]  shadow_kind [teq_pkg::DEPTH];
  int          shadow_fill = 0;

  teq_pkg::rsp_t owed_reports [$];
  int            mismatches = 0;
  int            idle_cycles = 0;

  // Idling percentages of the current phase.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Base of the random timestamps. It starts just short of the wrap, so the random
  // part carries the clock through zero.
  logic [31:0] time_base = 32'hFFFF_F000;

  time_ordered_event_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one request to the shadow queue and returns the report that it owes.
  function automatic teq_pkg::rsp_t update_shadow_queue(input teq_pkg::req_t beat);
    teq_pkg::rsp_t report;
    int            pos;
    logic [31:0]   diff;
    report = '0;
    pos = shadow_fill;
    if (beat.req_type == teq_pkg::REQ_INSERT) begin
      if (shadow_fill >= teq_pkg::DEPTH) begin
        report.status = teq_pkg::STATUS_FULL;
      end else begin
        // The new event goes in front of the first stored event that is strictly later.
        // Lateness is the sign of the wrapped difference.
        for (int k = 0; k < shadow_fill; k++) begin
          diff = beat.event_time - shadow_time[k];
          if (diff[31] && pos == shadow_fill) begin
            pos = k;
          end
        end
        for (int k = shadow_fill; k > pos; k--) begin
          shadow_time[k] = shadow_time[k - 1];
          shadow_kind[k] = shadow_kind[k - 1];
        end
        shadow_time[pos] = beat.event_time;
        shadow_kind[pos] = beat.event_type;
        shadow_fill++;
        report.status = teq_pkg::STATUS_DONE;
      end
    end else begin
      for (int k = 0; k < shadow_fill; k++) begin
        if (shadow_kind[k] == beat.event_type && pos == shadow_fill) begin
          pos = k;
        end
      end
      if (pos == shadow_fill) begin
        report.status = teq_pkg::STATUS_NOMATCH;
      end else begin
        for (int k = pos; k + 1 < shadow_fill; k++) begin
          shadow_time[k] = shadow_time[k + 1];
          shadow_kind[k] = shadow_kind[k + 1];
        end
        shadow_fill--;
        report.status = teq_pkg::STATUS_DONE;
      end
    end
    if (shadow_fill > 0) begin
      report.head_valid = 1'b1;
      report.head_time = shadow_time[0];
      report.head_type = shadow_kind[0];
    end
    report.fill_count = 5'(shadow_fill);
    return report;
  endfunction

  // Draws a random request. While fill_up is set, inserts are favored. Kinds come mostly
  // from a small pool, so that removes usually find something.
  function automatic teq_pkg::req_t random_request(input logic fill_up);
    teq_pkg::req_t beat;
    int            pick;
    beat.req_type = ($urandom_range(99) < (fill_up ? 75 : 25)) ?
                    teq_pkg::REQ_INSERT : teq_pkg::REQ_REMOVE;
    pick = $urandom_range(99);
    if (pick < 55) begin
      beat.event_time = time_base + 32'($urandom_range(40));
    end else if (pick < 70) begin
      beat.event_time = time_base - 32'($urandom_range(40));
    end else if (pick < 80) begin
      beat.event_time = time_base + 32'h8000_0000 - 32'($urandom_range(1));
    end else begin
      beat.event_time = $urandom();
    end
    beat.event_type = ($urandom_range(99) < 85) ? 8'($urandom_range(5)) : 8'($urandom());
    return beat;
  endfunction

  // Presents one beat, after a random gap, and holds it until it is accepted. The report
  // that the beat owes is queued at the edge that accepts it. A typed-in report, when
  // one is given, replaces the shadow queue's report, although the shadow queue is
  // still updated.
  task automatic send_request(input teq_pkg::req_t beat, input logic has_want,
                              input teq_pkg::rsp_t want);
    teq_pkg::rsp_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = update_shadow_queue(beat);
    owed_reports.push_back(has_want ? want : predicted);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH at %0t ns: %s is 0x%0h, should be 0x%0h", $time, field, got, want);
  endtask

  // Receiver side: random stalls, report checking and the watchdog.
  always @(posedge clk) begin : watch_reports
    teq_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (rsp_valid && !rsp_stall) begin
        if (owed_reports.size() == 0) begin
          report_mismatch("report with none owed, fill_count", 32'(rsp.fill_count), 32'd0);
        end else begin
          want = owed_reports.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.head_valid !== want.head_valid)
            report_mismatch("head_valid", 32'(rsp.head_valid), 32'(want.head_valid));
          if (rsp.head_time !== want.head_time)
            report_mismatch("head_time", rsp.head_time, want.head_time);
          if (rsp.head_type !== want.head_type)
            report_mismatch("head_type", 32'(rsp.head_type), 32'(want.head_type));
          if (rsp.fill_count !== want.fill_count)
            report_mismatch("fill_count", 32'(rsp.fill_count), 32'(want.fill_count));
        end
      end
    end
    // Any accepted beat on either side counts as progress.
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : drive_requests
    logic fill_up;
    fill_up = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      send_request(DIRECTED_ROWS[r].beat, DIRECTED_ROWS[r].has_want, DIRECTED_ROWS[r].want);
    end

    // Four idling phases: none, a slow sender, a slow receiver, and light idling on both.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1) ? 54 : (phase == 3) ? 7 : 0;
      receiver_stall_pct = (phase == 2) ? 54 : (phase == 3) ? 7 : 0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Swing between filling and draining, so the queue keeps hitting full and empty.
        if (shadow_fill >= teq_pkg::DEPTH) begin
          fill_up = 1'b0;
        end else if (shadow_fill == 0) begin
          fill_up = 1'b1;
        end
        time_base = ($urandom_range(99) < 2) ? $urandom() : time_base + $urandom_range(20);
        send_request(random_request(fill_up), 1'b0, '0);
      end
    end
    req_valid <= 1'b0;

    while (owed_reports.size() != 0) @(posedge clk);
    repeat (teq_pkg::DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
